// ----- hw/rtl/rls_pkg.sv -----
// Shared types, constants and the hash step for the repeat line suppressor.
package rls_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [31:0] WINDOW_RESET = 32'd10000;
  localparam logic [31:0] PERIOD_RESET = 32'd30000;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;

  localparam int QDEPTH = 2;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_PERIOD = 1'b1
  } reg_idx_e;

  // work handed from the line front end to the filter
  typedef struct packed {
    logic        is_flush;
    logic [31:0] hash;
    logic [31:0] now;
  } job_t;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] period;
  } cfg_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] x;
    x = h ^ {24'd0, c};
    return 32'(x * FNV_PRIME);
  endfunction

endpackage

// ----- hw/rtl/rls_if.sv -----
// Stream channels for line characters in and filter results out.
interface rls_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  line_char;
  logic        line_last;
  logic [31:0] now_ms;

  modport source (output valid, mode, line_char, line_last, now_ms, input ready);
  modport sink   (input valid, mode, line_char, line_last, now_ms, output ready);
endinterface

interface rls_out_if;
  logic        valid;
  logic        ready;
  logic        keep_line;
  logic [31:0] report_count;
  logic [31:0] line_hash;
  logic        from_flush;

  modport source (output valid, keep_line, report_count, line_hash, from_flush, input ready);
  modport sink   (input valid, keep_line, report_count, line_hash, from_flush, output ready);
endinterface

// ----- hw/rtl/rls_front.sv -----
// Front end: takes characters, hashes the line, emits end-of-line and flush jobs.
module rls_front #(
  parameter int LINE_MAX = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rls_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output rls_pkg::job_t job_o
);

  localparam int CntW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;

  logic [31:0]     hash_q, hash_d, hash_n;
  logic            inside_q, inside_d, inside_n;
  logic            done_q, done_d, done_n;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_n;
  logic            accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // one character step of the line state
  always_comb begin
    hash_n   = hash_q;
    inside_n = inside_q;
    done_n   = done_q;
    cnt_n    = cnt_q;
    if (cnt_q != CntW'(LINE_MAX - 1)) begin
      cnt_n = cnt_q + CntW'(1);
      if (!done_q && in_i.line_char == rls_pkg::CHAR_OPEN) begin
        inside_n = 1'b1;
      end else if (inside_q) begin
        if (in_i.line_char == rls_pkg::CHAR_CLOSE) begin
          inside_n = 1'b0;
          done_n   = 1'b1;
        end
      end else begin
        hash_n = rls_pkg::fnv_step(hash_q, in_i.line_char);
      end
    end
  end

  always_comb begin
    hash_d         = hash_q;
    inside_d       = inside_q;
    done_d         = done_q;
    cnt_d          = cnt_q;
    push_o         = 1'b0;
    job_o.is_flush = in_i.mode;
    job_o.hash     = hash_n;
    job_o.now      = in_i.now_ms;
    if (accept) begin
      if (in_i.mode) begin
        push_o = 1'b1;
      end else if (in_i.line_last) begin
        push_o   = 1'b1;
        hash_d   = rls_pkg::FNV_BASIS;
        inside_d = 1'b0;
        done_d   = 1'b0;
        cnt_d    = '0;
      end else begin
        hash_d   = hash_n;
        inside_d = inside_n;
        done_d   = done_n;
        cnt_d    = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= rls_pkg::FNV_BASIS;
      inside_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      hash_q   <= hash_d;
      inside_q <= inside_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/rls_queue.sv -----
// Small job queue between the front end and the filter.
module rls_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rls_pkg::job_t job_i,
  input  logic          pop_i,
  output rls_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (rls_pkg::QDEPTH > 1) ? $clog2(rls_pkg::QDEPTH) : 1;

  rls_pkg::job_t   mem_q [rls_pkg::QDEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PtrW + 1)'(rls_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(rls_pkg::QDEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(push_i) - (PtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ----- hw/rtl/rls_back.sv -----
// Filter: slot match, flood counting and the registered result word.
module rls_back #(
  parameter int SLOTS = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rls_pkg::cfg_t cfg_i,
  input  logic          q_empty_i,
  input  rls_pkg::job_t job_i,
  output logic          pop_o,
  rls_out_if.source     out_o
);

  logic [31:0] shash_q [SLOTS];
  logic [31:0] shash_d [SLOTS];
  logic [31:0] stime_q [SLOTS];
  logic [31:0] stime_d [SLOTS];
  logic [31:0] cnt_q, cnt_d, start_q, start_d;
  logic        ovalid_q, ovalid_d;
  logic        keep_q, keep_d, flush_q, flush_d;
  logic [31:0] report_q, report_d, ohash_q, ohash_d;
  logic        found, emit;
  logic [31:0] base, cnt_inc;

  assign pop_o = !q_empty_i && (!ovalid_q || out_o.ready);

  always_comb begin
    shash_d  = shash_q;
    stime_d  = stime_q;
    cnt_d    = cnt_q;
    start_d  = start_q;
    keep_d   = keep_q;
    flush_d  = flush_q;
    report_d = report_q;
    ohash_d  = ohash_q;
    emit     = 1'b0;
    found    = 1'b0;
    base     = (cnt_q == '0) ? job_i.now : start_q;
    cnt_inc  = cnt_q + 32'd1;
    // lowest matching live slot wins and gets its time refreshed
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && stime_q[i] != '0 && shash_q[i] == job_i.hash &&
          32'(job_i.now - stime_q[i]) < cfg_i.window) begin
        found = 1'b1;
        if (pop_o && !job_i.is_flush) begin
          stime_d[i] = job_i.now;
        end
      end
    end
    if (pop_o) begin
      if (job_i.is_flush) begin
        if (cnt_q != '0) begin
          emit     = 1'b1;
          keep_d   = 1'b0;
          flush_d  = 1'b1;
          report_d = cnt_q;
          ohash_d  = '0;
          cnt_d    = '0;
        end
      end else if (found) begin
        emit    = 1'b1;
        keep_d  = 1'b0;
        flush_d = 1'b0;
        ohash_d = job_i.hash;
        if (32'(job_i.now - base) >= cfg_i.period) begin
          report_d = cnt_inc;
          cnt_d    = '0;
          start_d  = job_i.now;
        end else begin
          report_d = '0;
          cnt_d    = cnt_inc;
          start_d  = base;
        end
      end else begin
        emit     = 1'b1;
        keep_d   = 1'b1;
        flush_d  = 1'b0;
        ohash_d  = job_i.hash;
        report_d = cnt_q;
        cnt_d    = '0;
        for (int i = SLOTS - 1; i > 0; i--) begin
          shash_d[i] = shash_q[i-1];
          stime_d[i] = stime_q[i-1];
        end
        shash_d[0] = job_i.hash;
        stime_d[0] = (job_i.now != '0) ? job_i.now : 32'd1;
      end
    end
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        shash_q[i] <= '0;
        stime_q[i] <= '0;
      end
      cnt_q    <= '0;
      start_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      shash_q  <= shash_d;
      stime_q  <= stime_d;
      cnt_q    <= cnt_d;
      start_q  <= start_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keep_q   <= keep_d;
    flush_q  <= flush_d;
    report_q <= report_d;
    ohash_q  <= ohash_d;
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.keep_line    = keep_q;
  assign out_o.from_flush   = flush_q;
  assign out_o.report_count = report_q;
  assign out_o.line_hash    = ohash_q;

endmodule

// ----- hw/rtl/repeat_line_suppressor.sv -----
// Top level of the repeat line suppressor: APB registers, front end, queue, filter.
//
//  channel  dir  handshake       word
//  in_i     in   valid/ready     mode, line_char, line_last, now_ms
//  out_o    out  valid/ready     keep_line, report_count, line_hash, from_flush
//  apb      in   psel/penable    two 32-bit registers at byte 0 and 4
//
// One character word per cycle while the job queue has room; the FNV-1a step
// (one constant multiply) closes the per-character loop in the front end.
// The job for a line end or flush passes through the job queue; the filter
// then writes its line result or flush answer into the output register.
// Reset clears line state, slots, flood count and queue; registers return to
// 10000 ms window and 30000 ms period.
// Stalls: the two-entry job queue decouples sides; in_i.ready drops only
// while the queue is full, out_o holds its word until taken.
module repeat_line_suppressor #(
  parameter int LINE_MAX = 256,
  parameter int SLOTS    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rls_in_if.sink      in_i,
  rls_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rls_pkg::cfg_t     cfg_q, cfg_d;
  rls_pkg::reg_idx_e reg_sel;
  rls_pkg::job_t     push_job, head_job;
  logic              q_push, q_pop, q_full, q_empty;

  // register file: word address picks the register, byte lanes ignored
  assign pready  = 1'b1;
  assign reg_sel = rls_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        rls_pkg::REG_WINDOW: cfg_d.window = pwdata;
        rls_pkg::REG_PERIOD: cfg_d.period = pwdata;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rls_pkg::REG_WINDOW: prdata = cfg_q.window;
      rls_pkg::REG_PERIOD: prdata = cfg_q.period;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= rls_pkg::WINDOW_RESET;
      cfg_q.period <= rls_pkg::PERIOD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rls_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .q_full_i(q_full),
    .push_o  (q_push),
    .job_o   (push_job)
  );

  rls_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .job_o  (head_job),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  rls_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_empty_i(q_empty),
    .job_i    (head_job),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

  // no job pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("job queue overflow");

  // no job taken from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("job queue underflow");

  // a flush answer always carries a nonzero count and never keeps a line
  a_flush_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.from_flush) |->
      (out_o.report_count != 32'd0 && !out_o.keep_line && out_o.line_hash == 32'd0))
    else $error("malformed flush result");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the repeat line suppressor: line hashing, repeat window, flood counts.
`timescale 1ns / 1ps

module tb_top;

  localparam int LINE_MAX      = 256;
  localparam int SLOTS         = 2;
  localparam int SETTLE_CYCLES = 8;   // idle margin after the last checked result
  localparam int MAX_REPORTS   = 10;
  localparam int POOL_LINES    = 4;
  localparam int POOL_MAX_LEN  = 12;
  localparam int LONG_LINE_LEN = LINE_MAX + 1;

  localparam logic MODE_CHAR  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  ch;
    logic        last;
    logic [31:0] now;
  } char_word_t;

  typedef struct packed {
    logic        keep;
    logic [31:0] report;
    logic [31:0] hash;
    logic        flush;
  } verdict_t;

  // where the uptime stamp goes in a line built from the pool
  typedef enum logic [2:0] {
    STAMP_NONE,
    STAMP_LEAD,
    STAMP_MID,
    STAMP_TWO,
    STAMP_OPEN,
    STAMP_STRAY
  } stamp_style_e;

  // receiver back-pressure styles, picked at random by the monitor
  typedef enum logic [1:0] {
    TAKE_ALL,
    TAKE_COIN,
    TAKE_QUARTER,
    TAKE_BLOCKS
  } take_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rls_in_if  in_if ();
  rls_out_if out_if ();

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Driver and receiver registers, known from time 0.
  logic       drv_valid  = 1'b0;
  char_word_t drv_word   = '0;
  logic       take_ready = 1'b0;

  assign in_if.valid     = drv_valid;
  assign in_if.mode      = drv_word.mode;
  assign in_if.line_char = drv_word.ch;
  assign in_if.line_last = drv_word.last;
  assign in_if.now_ms    = drv_word.now;
  assign out_if.ready    = take_ready;

  repeat_line_suppressor #(
    .LINE_MAX(LINE_MAX),
    .SLOTS   (SLOTS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of registers, line state, slots and flood count.
  // ---------------------------------------------------------------------------
  logic [31:0] win_ms;
  logic [31:0] period_ms;
  logic [31:0] line_acc;
  logic        in_stamp;
  logic        stamp_seen;
  int unsigned line_len;
  logic [31:0] recent_hash [SLOTS];
  logic [31:0] recent_time [SLOTS];   // 0 marks an empty slot
  logic [31:0] flood_cnt;
  logic [31:0] flood_start;

  char_word_t  pending_words [$];
  verdict_t    due_verdicts [$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned fault_cnt    = 0;

  function automatic void clear_line();
    line_acc   = rls_pkg::FNV_BASIS;
    in_stamp   = 1'b0;
    stamp_seen = 1'b0;
    line_len   = 0;
  endfunction

  function automatic void reset_model();
    win_ms    = rls_pkg::WINDOW_RESET;
    period_ms = rls_pkg::PERIOD_RESET;
    clear_line();
    for (int i = 0; i < SLOTS; i++) begin
      recent_hash[i] = '0;
      recent_time[i] = '0;
    end
    flood_cnt   = '0;
    flood_start = '0;
  endfunction

  // Returns 1 with the verdict when the word produces a result.
  function automatic bit judge_word(input char_word_t w, output verdict_t v);
    logic [31:0] age;
    bit          hit;
    v   = '0;
    hit = 1'b0;
    if (w.mode == MODE_FLUSH) begin
      if (flood_cnt == 0) return 1'b0;
      v.report  = flood_cnt;
      v.flush   = 1'b1;
      flood_cnt = '0;
      return 1'b1;
    end
    // only the first LINE_MAX-1 characters touch the hash
    if (line_len < LINE_MAX - 1) begin
      line_len++;
      if (!stamp_seen && w.ch == rls_pkg::CHAR_OPEN) begin
        in_stamp = 1'b1;
      end else if (in_stamp) begin
        if (w.ch == rls_pkg::CHAR_CLOSE) begin
          in_stamp   = 1'b0;
          stamp_seen = 1'b1;
        end
      end else begin
        line_acc = (line_acc ^ {24'd0, w.ch}) * rls_pkg::FNV_PRIME;
      end
    end
    if (!w.last) return 1'b0;

    v.hash = line_acc;
    clear_line();
    // lowest matching slot wins and gets its time refreshed
    for (int i = 0; i < SLOTS; i++) begin
      age = w.now - recent_time[i];
      if (!hit && recent_time[i] != 0 && recent_hash[i] == v.hash && age < win_ms) begin
        recent_time[i] = w.now;
        hit            = 1'b1;
      end
    end
    if (hit) begin
      if (flood_cnt == 0) flood_start = w.now;
      flood_cnt++;
      age = w.now - flood_start;
      if (age >= period_ms) begin
        v.report    = flood_cnt;
        flood_cnt   = '0;
        flood_start = w.now;
      end
    end else begin
      v.report  = flood_cnt;
      flood_cnt = '0;
      for (int i = SLOTS - 1; i > 0; i--) begin
        recent_hash[i] = recent_hash[i-1];
        recent_time[i] = recent_time[i-1];
      end
      recent_hash[0] = v.hash;
      recent_time[0] = (w.now != 0) ? w.now : 32'd1;
    end
    v.keep = !hit;
    return 1'b1;
  endfunction

  function automatic void flag_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending words, bursts of random length with random gaps.
  // The predictor runs on every word at the edge that accepts it.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    verdict_t v;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        words_taken++;
        if (judge_word(drv_word, v)) due_verdicts.push_back(v);
      end
      if (!drv_valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          drv_word  <= pending_words.pop_front();
          drv_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            // long back-to-back stretch
            burst_left = $urandom_range(30, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 5);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest due verdict and
  // drives the receiver's ready from its own stall pattern.
  // ---------------------------------------------------------------------------
  int unsigned take_tick  = 0;
  take_style_e take_style = TAKE_ALL;

  always @(posedge clk_i) begin : check_results
    verdict_t got;
    verdict_t want;
    if (out_if.valid && take_ready) begin
      got = {out_if.keep_line, out_if.report_count, out_if.line_hash, out_if.from_flush};
      if (due_verdicts.size() == 0) begin
        flag_fault($sformatf("unexpected result keep %0d report %0d hash %08h flush %0d",
                             got.keep, got.report, got.hash, got.flush));
      end else begin
        want = due_verdicts.pop_front();
        if (got.keep !== want.keep)
          flag_fault($sformatf("keep_line exp %0d got %0d", want.keep, got.keep));
        if (got.report !== want.report)
          flag_fault($sformatf("report_count exp %0d got %0d", want.report, got.report));
        if (got.hash !== want.hash)
          flag_fault($sformatf("line_hash exp %08h got %08h", want.hash, got.hash));
        if (got.flush !== want.flush)
          flag_fault($sformatf("from_flush exp %0d got %0d", want.flush, got.flush));
      end
    end
    take_tick++;
    if (take_tick % 50 == 0) take_style = take_style_e'($urandom_range(0, 3));
    case (take_style)
      TAKE_ALL:     take_ready <= 1'b1;
      TAKE_COIN:    take_ready <= 1'($urandom_range(0, 1));
      TAKE_QUARTER: take_ready <= (take_tick % 4 == 0);
      default:      take_ready <= (take_tick % 16 >= 8);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [7:0]  pool_txt [POOL_LINES][POOL_MAX_LEN];
  int unsigned pool_len [POOL_LINES];
  logic [7:0]  line_buf [$];
  logic [31:0] wall_ms = '0;

  function automatic void push_word(logic mode, logic [7:0] ch, logic last, logic [31:0] now);
    pending_words.push_back({mode, ch, last, now});
    words_queued++;
  endfunction

  // character, last flag and time are don't-care on a flush; randomize them
  function automatic void push_flush();
    push_word(MODE_FLUSH, 8'($urandom), 1'($urandom), $urandom);
  endfunction

  // sends line_buf; time matters only on the last character
  function automatic void push_line(logic [31:0] now, bit allow_split);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (allow_split && i > 0 && $urandom_range(0, 29) == 0) push_flush();
      if (i == line_buf.size() - 1) push_word(MODE_CHAR, line_buf[i], 1'b1, now);
      else push_word(MODE_CHAR, line_buf[i], 1'b0, $urandom);
    end
  endfunction

  // message bodies stay free of parentheses so stamps alone decide skipping
  function automatic void fill_pool();
    logic [7:0] c;
    for (int p = 0; p < POOL_LINES; p++) begin
      pool_len[p] = $urandom_range(1, POOL_MAX_LEN);
      for (int k = 0; k < POOL_MAX_LEN; k++) begin
        c = 8'($urandom_range(0, 255));
        if (c == rls_pkg::CHAR_OPEN || c == rls_pkg::CHAR_CLOSE) c = 8'h41;
        pool_txt[p][k] = c;
      end
    end
  endfunction

  function automatic void add_stamp();
    int unsigned n;
    n = $urandom_range(0, 5);
    line_buf.push_back(rls_pkg::CHAR_OPEN);
    if ($urandom_range(0, 7) == 0) line_buf.push_back(rls_pkg::CHAR_OPEN);   // nested open
    for (int k = 0; k < n; k++) line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
    line_buf.push_back(rls_pkg::CHAR_CLOSE);
  endfunction

  function automatic void add_body(int unsigned p, int unsigned from, int unsigned upto);
    for (int unsigned k = from; k < upto; k++) line_buf.push_back(pool_txt[p][k]);
  endfunction

  function automatic void build_pool_line(int unsigned p, stamp_style_e style);
    int unsigned cut;
    line_buf.delete();
    cut = $urandom_range(0, pool_len[p]);
    case (style)
      STAMP_LEAD: begin
        add_stamp();
        add_body(p, 0, pool_len[p]);
      end
      STAMP_MID: begin
        add_body(p, 0, cut);
        add_stamp();
        add_body(p, cut, pool_len[p]);
      end
      STAMP_TWO: begin
        add_stamp();
        add_stamp();
        add_body(p, 0, pool_len[p]);
      end
      STAMP_OPEN: begin
        // stamp never closes: rest of the line is skipped
        add_body(p, 0, cut);
        line_buf.push_back(rls_pkg::CHAR_OPEN);
        add_body(p, 0, $urandom_range(0, pool_len[p]));
      end
      STAMP_STRAY: begin
        line_buf.push_back(rls_pkg::CHAR_CLOSE);
        add_body(p, 0, pool_len[p]);
      end
      default: add_body(p, 0, pool_len[p]);
    endcase
  endfunction

  function automatic stamp_style_e pick_style();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return STAMP_NONE;
    if (r < 65) return STAMP_LEAD;
    if (r < 85) return STAMP_MID;
    if (r < 90) return STAMP_TWO;
    if (r < 95) return STAMP_OPEN;
    return STAMP_STRAY;
  endfunction

  // Mostly pool lines (repeats likely), some noise lines and flushes.
  // Time moves in small steps with the odd jump, wrap and exact zero.
  function automatic void random_traffic(int unsigned budget, int unsigned step_max);
    int unsigned first;
    int unsigned pick;
    int unsigned r;
    first = words_queued;
    pick  = 0;
    while (words_queued - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 3) wall_ms = $urandom;
      else if (r < 6) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max);
      else if (r < 7) wall_ms = '0;
      else wall_ms += $urandom_range(0, step_max);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_flush();
      end else begin
        if (r < 14) begin
          line_buf.delete();
          repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 1) == 1) pick = $urandom_range(0, POOL_LINES - 1);
          build_pool_line(pick, pick_style());
        end
        push_line(wall_ms, 1'b1);
      end
    end
  endfunction

  function automatic void push_text(string s, logic [31:0] now);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    push_line(now, 1'b0);
  endfunction

  task automatic wait_idle();
    while (words_taken != words_queued || due_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access; lands at the edge with penable high
  task automatic write_reg(rls_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rls_pkg::REG_WINDOW) win_ms = val;
    else period_ms = val;
  endtask

  task automatic set_limits(logic [31:0] window, logic [31:0] period);
    write_reg(rls_pkg::REG_WINDOW, window);
    write_reg(rls_pkg::REG_PERIOD, period);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    fill_pool();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset register values
    push_flush();                                   // nothing pending, no result
    push_word(MODE_CHAR, 8'h00, 1'b1, 32'd0);       // time 0 stored as 1
    push_word(MODE_CHAR, 8'h00, 1'b1, 32'd0);       // age wraps to all ones: miss
    push_word(MODE_CHAR, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_text("(7)", $urandom);                     // stamp then 0xFF: hit across wrap
    pending_words[pending_words.size()-1].last = 1'b0;
    push_word(MODE_CHAR, 8'hFF, 1'b1, 32'd100);
    push_word(MODE_CHAR, "A", 1'b0, $urandom);      // flush lands in mid-line
    push_flush();
    push_word(MODE_CHAR, "B", 1'b1, 32'd200);
    push_text("(ab", 32'd300);                      // unclosed stamp
    push_text(")x", 32'd400);                       // stray close is hashed
    push_text("()(", 32'd500);                      // open after a finished stamp is hashed
    push_text(")x", 32'd700);                       // hit in the older slot
    push_flush();
    wall_ms = 32'd1000;
    random_traffic(40, 6000);
    wait_idle();

    // huge window, zero period: every repeat reports at once; one over-long line
    set_limits(32'hFFFF_FFFF, 32'd0);
    line_buf.delete();
    repeat (LONG_LINE_LEN) line_buf.push_back(8'($urandom_range(0, 255)));
    push_line(wall_ms, 1'b0);
    random_traffic(25, 3000);
    wait_idle();

    // zero window never matches
    set_limits(32'd0, 32'hFFFF_FFFF);
    random_traffic(25, 2000);
    wait_idle();

    // smallest settings: only same-millisecond repeats match
    set_limits(32'd1, 32'd1);
    random_traffic(35, 1);
    wait_idle();

    set_limits($urandom_range(100, 5000), $urandom_range(1000, 20000));
    random_traffic(50, 4000);
    wait_idle();

    // largest settings: floods build until a miss or a flush
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_traffic(40, 50000);
    wait_idle();

    if (fault_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rls_pkg.sv
hw/rtl/rls_if.sv
hw/rtl/rls_front.sv
hw/rtl/rls_queue.sv
hw/rtl/rls_back.sv
hw/rtl/repeat_line_suppressor.sv
sim/tb_top.sv
